@@ design/ordered_list_table_top_macros.svh @@
// Assertion macros shared by the ordered list table RTL.
`ifndef ORDERED_LIST_TABLE_TOP_MACROS_SVH
`define ORDERED_LIST_TABLE_TOP_MACROS_SVH

// Clocked assertion, held off while reset is asserted
`define OLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen
`define OLT_ASSERT_NEVER(lbl, cond, msg) \
  `OLT_ASSERT(lbl, !(cond), msg)

`endif

@@ design/olt_pkg.sv @@
// Shared types and constants of the ordered list table.
package olt_pkg;

  // Field widths of the stream payloads
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ITEM_W   = 16;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned RCOUNT_W = 5;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 32;

  // Match bits examined per scan cycle
  localparam int unsigned SCAN_W  = 8;
  localparam int unsigned SCAN_LG = 3;

  // Operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_INS_FRONT = 2'd0,
    MODE_INS_REAR  = 2'd1,
    MODE_SEARCH    = 2'd2,
    MODE_REMOVE    = 2'd3
  } mode_e;

  // Per-cell command
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_BACK,
    CELL_SHIFT_FWD,
    CELL_LOAD,
    CELL_MATCH
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     live;
  } cell_ctl_t;

  // Controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } ctrl_state_e;

endpackage

@@ design/ordered_list_table_top.sv @@
// Ordered list table: cell row, find-first scanner and operation controller.
//
// Holds up to DEPTH values in a row of cells, position 0 first. Each input
// transfer carries one operation (insert at front, insert at rear, search,
// remove at position) and yields exactly one result transfer. Inserts and
// removals update the row in parallel: the cells concerned shift from a
// neighbor or load the new value. In a search all cells compare first, then
// the scanner walks the match flags eight per cycle and stops at the first
// hit or after the last group. One operation is in flight at a time; a new
// input is taken once the result register is empty or being drained.
// Entries beyond the current count are never read, and need no clearing.
`include "ordered_list_table_top_macros.svh"

module ordered_list_table_top import olt_pkg::*; #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // [1:0] mode, [17:2] item_value, [21:18] position, [23:22] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] removed_value, [19:16] found_position, [20] found, [21] error,
  // [26:22] entry_count, [31:27] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready
);

  localparam int unsigned CNTW   = $clog2(DEPTH + 1);
  localparam int unsigned RM_N   = (DEPTH < 16) ? DEPTH : 16;
  localparam int unsigned NCHUNK = (DEPTH + SCAN_W - 1) / SCAN_W;
  localparam int unsigned SPW    = ((NCHUNK > 1) ? $clog2(NCHUNK) : 1) + SCAN_LG;

  ctrl_state_e state_q, state_d;
  logic [CNTW-1:0] count_q, count_d;

  // Input fields
  mode_e                  in_mode;
  logic [ITEM_W-1:0]      in_item;
  logic [POS_W-1:0]       in_pos;
  logic [VALUE_WIDTH-1:0] key;
  logic                   in_fire;

  // Cell row
  cell_ctl_t              cell_ctl [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]       cell_match;

  // Scanner
  logic           scan_start, scan_done, scan_hit;
  logic [SPW-1:0] scan_pos;

  // Result register
  logic                out_valid_q, out_valid_d;
  logic                res_load;
  logic [ITEM_W-1:0]   res_rv, out_rv_q;
  logic [POS_W-1:0]    res_fp, out_fp_q;
  logic                res_found, out_found_q;
  logic                res_err, out_err_q;
  logic [RCOUNT_W-1:0] res_cnt, out_cnt_q;

  logic                   full, rm_ok;
  logic [VALUE_WIDTH-1:0] rm_val;

  assign in_mode = mode_e'(s_axis_tdata[1:0]);
  assign in_item = s_axis_tdata[17:2];
  assign in_pos  = s_axis_tdata[21:18];
  assign key     = VALUE_WIDTH'(in_item);

  // Row of cells; each takes from its neighbors
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_v, next_v;
    if (k == 0) begin : g_head
      assign prev_v = key;
    end else begin : g_body
      assign prev_v = cell_val[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign next_v = cell_val[k];
    end else begin : g_inner
      assign next_v = cell_val[k+1];
    end
    olt_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[k]),
      .key_i   (key),
      .prev_i  (prev_v),
      .next_i  (next_v),
      .value_o (cell_val[k]),
      .match_o (cell_match[k])
    );
  end

  olt_scan #(.DEPTH(DEPTH)) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .match_i (cell_match),
    .done_o  (scan_done),
    .hit_o   (scan_hit),
    .pos_o   (scan_pos)
  );

  // Table status and removal read-out
  always_comb begin
    full   = (count_q == CNTW'(DEPTH));
    rm_ok  = (int'(in_pos) < int'(count_q)) && (int'(in_pos) < DEPTH);
    rm_val = '0;
    for (int k = 0; k < RM_N; k++) begin
      if (int'(in_pos) == k) rm_val = rm_val | cell_val[k];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire && (in_mode == MODE_SEARCH)) state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: handshake, cell commands, count and result
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
    in_fire       = s_axis_tvalid && s_axis_tready;
    scan_start    = 1'b0;
    res_load      = 1'b0;
    res_rv        = '0;
    res_fp        = '0;
    res_found     = 1'b0;
    res_err       = 1'b0;
    count_d       = count_q;
    for (int k = 0; k < DEPTH; k++) begin
      cell_ctl[k].op   = CELL_HOLD;
      cell_ctl[k].live = (k < int'(count_q));
    end
    if (in_fire) begin
      res_load = (in_mode != MODE_SEARCH);
      case (in_mode)
        MODE_INS_FRONT: begin
          if (full) begin
            res_err = 1'b1;
          end else begin
            count_d = count_q + CNTW'(1);
            for (int k = 0; k < DEPTH; k++) begin
              cell_ctl[k].op = (k == 0) ? CELL_LOAD : CELL_SHIFT_BACK;
            end
          end
        end
        MODE_INS_REAR: begin
          if (full) begin
            res_err = 1'b1;
          end else begin
            count_d = count_q + CNTW'(1);
            for (int k = 0; k < DEPTH; k++) begin
              if (k == int'(count_q)) cell_ctl[k].op = CELL_LOAD;
            end
          end
        end
        MODE_SEARCH: begin
          scan_start = 1'b1;
          for (int k = 0; k < DEPTH; k++) begin
            cell_ctl[k].op = CELL_MATCH;
          end
        end
        MODE_REMOVE: begin
          if (!rm_ok) begin
            res_err = 1'b1;
          end else begin
            count_d = count_q - CNTW'(1);
            res_rv  = ITEM_W'(rm_val);
            for (int k = 0; k < DEPTH; k++) begin
              if (k >= int'(in_pos)) cell_ctl[k].op = CELL_SHIFT_FWD;
            end
          end
        end
        default: ;
      endcase
    end
    // Search result once the scanner stops
    if (scan_done) begin
      res_load  = 1'b1;
      res_found = scan_hit;
      res_fp    = scan_hit ? POS_W'(scan_pos) : '0;
    end
    res_cnt = RCOUNT_W'(count_d);
  end

  // Result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_rv_q    <= res_rv;
      out_fp_q    <= res_fp;
      out_found_q <= res_found;
      out_err_q   <= res_err;
      out_cnt_q   <= res_cnt;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_cnt_q, out_err_q, out_found_q, out_fp_q, out_rv_q};

  // Checks
  `OLT_ASSERT(a_count_bound, count_q <= CNTW'(DEPTH), "entry count beyond table depth")
  `OLT_ASSERT_NEVER(a_scan_out_busy, (state_q == ST_SCAN) && out_valid_q, "output busy in scan")
  `OLT_ASSERT(a_direct_result, res_load |=> m_axis_tvalid, "result missing after load")
  `OLT_ASSERT_NEVER(a_found_err, m_axis_tvalid && out_found_q && out_err_q, "hit with error")

endmodule

@@ design/olt_cell.sv @@
// One storage cell of the ordered list: holds an entry and its match flag.
module olt_cell import olt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  cell_ctl_t              ctl_i,
  input  logic [VALUE_WIDTH-1:0] key_i,
  input  logic [VALUE_WIDTH-1:0] prev_i,   // entry of the cell in front
  input  logic [VALUE_WIDTH-1:0] next_i,   // entry of the cell behind
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic                   match_o
);

  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic                   match_q, match_d;

  // Next entry and match flag
  always_comb begin
    value_d = value_q;
    match_d = match_q;
    case (ctl_i.op)
      CELL_SHIFT_BACK: value_d = prev_i;
      CELL_SHIFT_FWD:  value_d = next_i;
      CELL_LOAD:       value_d = key_i;
      CELL_MATCH:      match_d = ctl_i.live && (value_q == key_i);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    match_q <= match_d;
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

@@ design/olt_scan.sv @@
// Find-first scanner over the cells' match flags, one group per cycle.
module olt_scan import olt_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned NCHUNK   = (DEPTH + SCAN_W - 1) / SCAN_W,
  localparam int unsigned CW       = (NCHUNK > 1) ? $clog2(NCHUNK) : 1,
  localparam int unsigned PW       = CW + SCAN_LG
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,   // starts a scan from the first group; match_i is read directly
  input  logic [DEPTH-1:0] match_i,
  output logic             done_o,
  output logic             hit_o,
  output logic [PW-1:0]    pos_o
);

  localparam int unsigned NCHUNK_P = 1 << CW;
  localparam int unsigned PADW     = NCHUNK_P * SCAN_W;
  localparam logic [CW-1:0] LAST   = CW'(NCHUNK - 1);

  logic              busy_q, busy_d;
  logic [CW-1:0]     chunk_q, chunk_d;
  logic [PADW-1:0]   match_pad;
  logic [SCAN_W-1:0] win;
  logic [SCAN_LG-1:0] enc;

  // Current group of flags and its lowest set bit
  always_comb begin
    match_pad = PADW'(match_i);
    win       = match_pad[{chunk_q, SCAN_LG'(0)} +: SCAN_W];
    enc       = '0;
    for (int b = SCAN_W - 1; b >= 0; b--) begin
      if (win[b]) enc = SCAN_LG'(b);
    end
  end

  assign hit_o  = |win;
  assign done_o = busy_q && (hit_o || (chunk_q == LAST));
  assign pos_o  = {chunk_q, enc};

  // Scan progress
  always_comb begin
    busy_d  = busy_q;
    chunk_d = chunk_q;
    if (start_i) begin
      busy_d  = 1'b1;
      chunk_d = '0;
    end else if (done_o) begin
      busy_d  = 1'b0;
    end else if (busy_q) begin
      chunk_d = chunk_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      chunk_q <= '0;
    end else begin
      busy_q  <= busy_d;
      chunk_q <= chunk_d;
    end
  end

endmodule
